>>> sv/ssl_pkg.sv
`timescale 1ns / 1ps
// Package for the script source lexer: request and token payload types,
// lexer modes, token kind codes and character codes. Depends on nothing.
package ssl_pkg;

  // Width of the offsets carried in a token.
  localparam int OUT_W = 24;

  typedef struct packed {
    logic       cmd;
    logic [7:0] source_byte;
  } ssl_in_t;

  typedef struct packed {
    logic [4:0]       token_kind;
    logic [OUT_W-1:0] start_offset;
    logic [OUT_W-1:0] end_offset;
    logic             last_of_run;
  } ssl_tok_t;

  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_IDENT      = 4'd1,
    M_NUMBER     = 4'd2,
    M_STRING     = 4'd3,
    M_STR_ESC    = 4'd4,
    M_SLASH      = 4'd5,
    M_EQ         = 4'd6,
    M_LT         = 4'd7,
    M_GT         = 4'd8,
    M_LINE       = 4'd9,
    M_BLOCK      = 4'd10,
    M_BLOCK_STAR = 4'd11
  } mode_e;

  // Per-request summary handed from the step logic to the top level.
  typedef struct packed {
    logic [1:0] n_res;
    mode_e      mode;
  } ssl_ctl_t;

  // Request command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Token kinds.
  localparam logic [4:0] K_EOF       = 5'd0;
  localparam logic [4:0] K_INVALID   = 5'd1;
  localparam logic [4:0] K_NEWLINE   = 5'd2;
  localparam logic [4:0] K_IDENT     = 5'd3;
  localparam logic [4:0] K_STRING    = 5'd4;
  localparam logic [4:0] K_NUMBER    = 5'd5;
  localparam logic [4:0] K_LBRACE    = 5'd6;
  localparam logic [4:0] K_RBRACE    = 5'd7;
  localparam logic [4:0] K_LPAREN    = 5'd8;
  localparam logic [4:0] K_RPAREN    = 5'd9;
  localparam logic [4:0] K_SEMI      = 5'd10;
  localparam logic [4:0] K_COMMA     = 5'd11;
  localparam logic [4:0] K_ASSIGN    = 5'd12;
  localparam logic [4:0] K_NE        = 5'd13;
  localparam logic [4:0] K_LT        = 5'd14;
  localparam logic [4:0] K_LE        = 5'd15;
  localparam logic [4:0] K_GT        = 5'd16;
  localparam logic [4:0] K_GE        = 5'd17;
  localparam logic [4:0] K_EQ        = 5'd18;
  localparam logic [4:0] K_PLUS      = 5'd19;
  localparam logic [4:0] K_MINUS     = 5'd20;
  localparam logic [4:0] K_STAR      = 5'd21;
  localparam logic [4:0] K_SLASH     = 5'd22;
  localparam logic [4:0] K_PERCENT   = 5'd23;
  localparam logic [4:0] K_UNTERM    = 5'd24;

  // Character codes.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

endpackage

>>> sv/ssl_step.sv
`timescale 1ns / 1ps
// Combinational lexer step: next mode, offsets and up to two tokens for one
// request. Depends on ssl_pkg.
module ssl_step #(
  parameter int OFFSET_WIDTH = 24
) (
  input  ssl_pkg::ssl_in_t          req_i,
  input  logic                      emit_nl_i,
  input  ssl_pkg::mode_e            mode_i,
  input  logic [OFFSET_WIDTH-1:0]   tstart_i,
  input  logic [OFFSET_WIDTH-1:0]   pos_i,
  output ssl_pkg::ssl_ctl_t         ctl_o,
  output logic [OFFSET_WIDTH-1:0]   tstart_o,
  output logic [OFFSET_WIDTH-1:0]   pos_o,
  output ssl_pkg::ssl_tok_t [1:0]   tok_o
);

  localparam int OutW = ssl_pkg::OUT_W;
  localparam logic [OFFSET_WIDTH-1:0] PosOne = {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic           emit;
    logic [4:0]     kind;
    ssl_pkg::mode_e mode;
    logic           take_start;
  } fresh_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= ssl_pkg::CH_0) && (b <= ssl_pkg::CH_9);
  endfunction

  function automatic logic is_ident_first(logic [7:0] b);
    return b[7] || ((b >= ssl_pkg::CH_LA) && (b <= ssl_pkg::CH_LZ)) ||
           ((b >= ssl_pkg::CH_UA) && (b <= ssl_pkg::CH_UZ)) || (b == ssl_pkg::CH_US);
  endfunction

  // Lexes a byte from the idle mode.
  function automatic fresh_t lex_fresh(logic [7:0] b, logic nl);
    fresh_t f;
    f.emit       = 1'b0;
    f.kind       = ssl_pkg::K_INVALID;
    f.mode       = ssl_pkg::M_IDLE;
    f.take_start = 1'b0;
    if (is_ident_first(b)) begin
      f.mode       = ssl_pkg::M_IDENT;
      f.take_start = 1'b1;
    end else if (is_digit(b)) begin
      f.mode       = ssl_pkg::M_NUMBER;
      f.take_start = 1'b1;
    end else begin
      case (b)
        ssl_pkg::CH_LF: begin
          f.emit = nl;
          f.kind = ssl_pkg::K_NEWLINE;
        end
        ssl_pkg::CH_CR, ssl_pkg::CH_TAB, ssl_pkg::CH_SPACE: f.emit = 1'b0;
        ssl_pkg::CH_DQUOTE: begin
          f.mode       = ssl_pkg::M_STRING;
          f.take_start = 1'b1;
        end
        ssl_pkg::CH_SLASH: begin
          f.mode       = ssl_pkg::M_SLASH;
          f.take_start = 1'b1;
        end
        ssl_pkg::CH_EQ: begin
          f.mode       = ssl_pkg::M_EQ;
          f.take_start = 1'b1;
        end
        ssl_pkg::CH_LT: begin
          f.mode       = ssl_pkg::M_LT;
          f.take_start = 1'b1;
        end
        ssl_pkg::CH_GT: begin
          f.mode       = ssl_pkg::M_GT;
          f.take_start = 1'b1;
        end
        ssl_pkg::CH_LBRACE: begin f.emit = 1'b1; f.kind = ssl_pkg::K_LBRACE;  end
        ssl_pkg::CH_RBRACE: begin f.emit = 1'b1; f.kind = ssl_pkg::K_RBRACE;  end
        ssl_pkg::CH_LPAREN: begin f.emit = 1'b1; f.kind = ssl_pkg::K_LPAREN;  end
        ssl_pkg::CH_RPAREN: begin f.emit = 1'b1; f.kind = ssl_pkg::K_RPAREN;  end
        ssl_pkg::CH_SEMI:   begin f.emit = 1'b1; f.kind = ssl_pkg::K_SEMI;    end
        ssl_pkg::CH_COMMA:  begin f.emit = 1'b1; f.kind = ssl_pkg::K_COMMA;   end
        ssl_pkg::CH_PLUS:   begin f.emit = 1'b1; f.kind = ssl_pkg::K_PLUS;    end
        ssl_pkg::CH_MINUS:  begin f.emit = 1'b1; f.kind = ssl_pkg::K_MINUS;   end
        ssl_pkg::CH_STAR:   begin f.emit = 1'b1; f.kind = ssl_pkg::K_STAR;    end
        ssl_pkg::CH_PCT:    begin f.emit = 1'b1; f.kind = ssl_pkg::K_PERCENT; end
        default: begin
          f.emit = 1'b1;
          f.kind = ssl_pkg::K_INVALID;
        end
      endcase
    end
    return f;
  endfunction

  logic [7:0]              b;
  logic [OFFSET_WIDTH-1:0] nx;
  fresh_t                  fr;
  logic                    e0, e1;
  logic [4:0]              k0, k1;
  logic [OFFSET_WIDTH-1:0] s0, s1, f0, f1;
  ssl_pkg::mode_e          nmode;
  logic                    op_close;

  assign b  = req_i.source_byte;
  // Positions saturate at all ones.
  assign nx = (pos_i == '1) ? pos_i : pos_i + PosOne;
  assign fr = lex_fresh(b, emit_nl_i);

  always_comb begin
    e0       = 1'b0;
    e1       = 1'b0;
    k0       = ssl_pkg::K_EOF;
    k1       = ssl_pkg::K_EOF;
    s0       = tstart_i;
    f0       = pos_i;
    s1       = pos_i;
    f1       = nx;
    nmode    = mode_i;
    tstart_o = tstart_i;
    pos_o    = nx;
    op_close = 1'b0;
    if (req_i.cmd == ssl_pkg::CMD_END) begin
      // Flush the pending token, then end of file at the current position.
      e0 = 1'b1;
      case (mode_i)
        ssl_pkg::M_IDENT:                     k0 = ssl_pkg::K_IDENT;
        ssl_pkg::M_NUMBER:                    k0 = ssl_pkg::K_NUMBER;
        ssl_pkg::M_STRING, ssl_pkg::M_STR_ESC: k0 = ssl_pkg::K_UNTERM;
        ssl_pkg::M_SLASH:                     k0 = ssl_pkg::K_SLASH;
        ssl_pkg::M_EQ:                        k0 = ssl_pkg::K_ASSIGN;
        ssl_pkg::M_LT:                        k0 = ssl_pkg::K_LT;
        ssl_pkg::M_GT:                        k0 = ssl_pkg::K_GT;
        default:                              e0 = 1'b0;
      endcase
      if (e0) begin
        e1 = 1'b1;
        k1 = ssl_pkg::K_EOF;
        f1 = pos_i;
      end else begin
        e0 = 1'b1;
        k0 = ssl_pkg::K_EOF;
        s0 = pos_i;
      end
      nmode    = ssl_pkg::M_IDLE;
      tstart_o = '0;
      pos_o    = '0;
    end else begin
      case (mode_i)
        ssl_pkg::M_IDENT: begin
          if (!(is_ident_first(b) || is_digit(b))) begin
            e0 = 1'b1;
            k0 = ssl_pkg::K_IDENT;
            op_close = 1'b1;
          end
        end
        ssl_pkg::M_NUMBER: begin
          if (!is_digit(b)) begin
            e0 = 1'b1;
            k0 = ssl_pkg::K_NUMBER;
            op_close = 1'b1;
          end
        end
        ssl_pkg::M_STRING: begin
          if (b == ssl_pkg::CH_BSLASH) begin
            nmode = ssl_pkg::M_STR_ESC;
          end else if (b == ssl_pkg::CH_DQUOTE) begin
            e0    = 1'b1;
            k0    = ssl_pkg::K_STRING;
            f0    = nx;
            nmode = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_STR_ESC: nmode = ssl_pkg::M_STRING;
        ssl_pkg::M_SLASH, ssl_pkg::M_EQ, ssl_pkg::M_LT, ssl_pkg::M_GT: begin
          if (mode_i == ssl_pkg::M_SLASH && b == ssl_pkg::CH_SLASH) begin
            nmode = ssl_pkg::M_LINE;
          end else if (mode_i == ssl_pkg::M_SLASH && b == ssl_pkg::CH_STAR) begin
            nmode = ssl_pkg::M_BLOCK;
          end else if (b == ssl_pkg::CH_EQ) begin
            // Two-character operator.
            e0    = 1'b1;
            f0    = nx;
            nmode = ssl_pkg::M_IDLE;
            case (mode_i)
              ssl_pkg::M_SLASH: k0 = ssl_pkg::K_NE;
              ssl_pkg::M_EQ:    k0 = ssl_pkg::K_EQ;
              ssl_pkg::M_LT:    k0 = ssl_pkg::K_LE;
              default:          k0 = ssl_pkg::K_GE;
            endcase
          end else begin
            e0 = 1'b1;
            op_close = 1'b1;
            case (mode_i)
              ssl_pkg::M_SLASH: k0 = ssl_pkg::K_SLASH;
              ssl_pkg::M_EQ:    k0 = ssl_pkg::K_ASSIGN;
              ssl_pkg::M_LT:    k0 = ssl_pkg::K_LT;
              default:          k0 = ssl_pkg::K_GT;
            endcase
          end
        end
        ssl_pkg::M_LINE: begin
          if (b == ssl_pkg::CH_LF) nmode = ssl_pkg::M_IDLE;
        end
        ssl_pkg::M_BLOCK: begin
          if (b == ssl_pkg::CH_STAR) nmode = ssl_pkg::M_BLOCK_STAR;
        end
        ssl_pkg::M_BLOCK_STAR: begin
          if (b == ssl_pkg::CH_SLASH) begin
            nmode = ssl_pkg::M_IDLE;
          end else if (b != ssl_pkg::CH_STAR) begin
            nmode = ssl_pkg::M_BLOCK;
          end
        end
        default: begin
          // Idle: the byte is lexed fresh into the first slot.
          e0    = fr.emit;
          k0    = fr.kind;
          s0    = pos_i;
          f0    = nx;
          nmode = fr.mode;
          if (fr.take_start) tstart_o = pos_i;
        end
      endcase
      // A byte that ended a pending token is lexed again into the second slot.
      if (op_close) begin
        e1    = fr.emit;
        k1    = fr.kind;
        nmode = fr.mode;
        if (fr.take_start) tstart_o = pos_i;
      end
    end
  end

  assign ctl_o.n_res = {1'b0, e0} + {1'b0, e1};
  assign ctl_o.mode  = nmode;

  assign tok_o[0].token_kind   = k0;
  assign tok_o[0].start_offset = OutW'(s0);
  assign tok_o[0].end_offset   = OutW'(f0);
  assign tok_o[0].last_of_run  = !e1;
  assign tok_o[1].token_kind   = k1;
  assign tok_o[1].start_offset = OutW'(s1);
  assign tok_o[1].end_offset   = OutW'(f1);
  assign tok_o[1].last_of_run  = 1'b1;

endmodule

>>> sv/script_source_lexer.sv
`timescale 1ns / 1ps
// Script source lexer: streams source bytes in and C-style tokens out.
// Instantiates ssl_step; uses types and constants from ssl_pkg.
//
// Usage:
//   Requests arrive on in_valid_i / in_stall_o / in_data_i. Each carries a
//   source byte (cmd 0) or an end-of-source mark (cmd 1). A request is taken
//   at a rising edge with in_valid_i high and in_stall_o low.
//   Tokens leave on out_valid_o / out_stall_i / out_data_o. One request gives
//   zero, one or two tokens; last_of_run flags the final one of a request.
//   cfg_we_i writes cfg_wdata_i into the emit_newlines register; write it only
//   while no request is in flight.
// Path: a request is registered, then lexed once the token queue has room, and
//   its tokens land in a four-entry token queue that drives out_data_o.
// Throughput: one request per cycle while each request yields at most one
//   token and the receiver does not stall. The queue drains one token per
//   cycle while out_stall_i is low; requests that yield two tokens fill it.
// Stall: the queue keeps two free entries for the lexing stage; when the
//   receiver stalls, the queue fills and in_stall_o rises. Nothing is lost.
// Reset: mode idle, offsets zero, emit_newlines cleared, queue empty.
//   An end-of-source request also returns mode and offsets to zero.
module script_source_lexer #(
  parameter int OFFSET_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ssl_pkg::ssl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssl_pkg::ssl_tok_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Lexer state.
  ssl_pkg::mode_e          mode_q;
  logic [OFFSET_WIDTH-1:0] tstart_q, pos_q;
  logic                    emit_nl_q;

  // Request register in front of the lexing logic.
  logic              req_valid_q;
  ssl_pkg::ssl_in_t  req_q;

  // Token queue.
  ssl_pkg::ssl_tok_t fifo_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  // Step outputs.
  ssl_pkg::ssl_ctl_t       ctl;
  logic [OFFSET_WIDTH-1:0] tstart_d, pos_d;
  ssl_pkg::ssl_tok_t [1:0] tok;

  logic accept, proc, pop;
  logic [QPtrW-1:0] wr_ptr_nx;

  ssl_step #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_step (
    .req_i     (req_q),
    .emit_nl_i (emit_nl_q),
    .mode_i    (mode_q),
    .tstart_i  (tstart_q),
    .pos_i     (pos_q),
    .ctl_o     (ctl),
    .tstart_o  (tstart_d),
    .pos_o     (pos_d),
    .tok_o     (tok)
  );

  // The registered request is lexed once the queue can hold its two
  // worst-case tokens.
  assign proc        = req_valid_q && (cnt_q <= QCntW'(QDepth - 2));
  assign in_stall_o  = req_valid_q && !proc;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nx   = wr_ptr_q + QPtrW'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (proc) cnt_d = cnt_d + QCntW'(ctl.n_res);
    if (pop)  cnt_d = cnt_d - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      mode_q      <= ssl_pkg::M_IDLE;
      tstart_q    <= '0;
      pos_q       <= '0;
      emit_nl_q   <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      if (accept) begin
        req_valid_q <= 1'b1;
      end else if (proc) begin
        req_valid_q <= 1'b0;
      end
      if (cfg_we_i) emit_nl_q <= cfg_wdata_i;
      if (proc) begin
        mode_q   <= ctl.mode;
        tstart_q <= tstart_d;
        pos_q    <= pos_d;
        wr_ptr_q <= wr_ptr_q + QPtrW'(ctl.n_res);
      end
      if (pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
    if (proc && ctl.n_res != 2'd0) fifo_q[wr_ptr_q] <= tok[0];
    if (proc && ctl.n_res == 2'd2) fifo_q[wr_ptr_nx] <= tok[1];
  end

  // The token queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("token queue overflow");

  // End of source returns the lexer to its reset state.
  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && req_q.cmd == ssl_pkg::CMD_END |=>
      pos_q == '0 && tstart_q == '0 && mode_q == ssl_pkg::M_IDLE)
    else $error("end of source did not reset the lexer");

  // End of source always yields at least the eof token.
  a_eof_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && req_q.cmd == ssl_pkg::CMD_END |-> ctl.n_res != 2'd0)
    else $error("end of source produced no token");

  // A two-token request marks only its second token as last.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && ctl.n_res == 2'd2 |-> !tok[0].last_of_run && tok[1].last_of_run)
    else $error("last_of_run misplaced");

  // Byte requests never move the position backwards.
  a_pos_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && req_q.cmd == ssl_pkg::CMD_BYTE |=> pos_q >= $past(pos_q))
    else $error("byte position went backwards");

endmodule

>>> tb/sv/tb_script_source_lexer.sv
`timescale 1ns / 1ps
// Self-checking testbench for script_source_lexer: random C-like source text goes in, and
// every token is checked against a cycle-free scanner kept in a small scoreboard class.
// Depends on ssl_pkg and script_source_lexer.
module tb_script_source_lexer;

  // The block runs at a narrower offset width than its default.
  localparam int          POS_W       = 16;
  localparam logic [31:0] POS_MAX     = (32'd1 << POS_W) - 32'd1;
  localparam int          DRAIN_CYC   = 4;
  localparam int          HOLD_CYC    = 80;
  localparam int          STUCK_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 160;

  // Single-byte operators, including the ones that wait for a possible '='.
  localparam logic [7:0] OP_CHARS [14] = '{
    ssl_pkg::CH_LBRACE, ssl_pkg::CH_RBRACE, ssl_pkg::CH_LPAREN, ssl_pkg::CH_RPAREN,
    ssl_pkg::CH_SEMI, ssl_pkg::CH_COMMA, ssl_pkg::CH_PLUS, ssl_pkg::CH_MINUS,
    ssl_pkg::CH_STAR, ssl_pkg::CH_PCT, ssl_pkg::CH_EQ, ssl_pkg::CH_LT, ssl_pkg::CH_GT,
    ssl_pkg::CH_SLASH};
  localparam logic [7:0] LOOKAHEAD_CHARS [4] = '{
    ssl_pkg::CH_LT, ssl_pkg::CH_GT, ssl_pkg::CH_EQ, ssl_pkg::CH_SLASH};

  // Tracks the scanner state and holds the tokens still owed by the block.
  class lexer_tracker;
    ssl_pkg::mode_e    mode;
    logic [31:0]       tok_start;
    logic [31:0]       byte_pos;
    logic              newlines;
    ssl_pkg::ssl_tok_t pending_tokens[$];
    ssl_pkg::ssl_tok_t run_tokens[$];
    int unsigned       errors;

    function new();
      mode      = ssl_pkg::M_IDLE;
      tok_start = '0;
      byte_pos  = '0;
      newlines  = 1'b0;
      errors    = 0;
    endfunction

    function void set_newlines(logic v);
      newlines = v;
    endfunction

    function int pending();
      return pending_tokens.size();
    endfunction

    function logic [31:0] sat_inc(logic [31:0] p);
      return (p >= POS_MAX) ? POS_MAX : p + 32'd1;
    endfunction

    function logic ident_first(logic [7:0] b);
      return b >= 8'd128 || (b >= ssl_pkg::CH_LA && b <= ssl_pkg::CH_LZ) ||
             (b >= ssl_pkg::CH_UA && b <= ssl_pkg::CH_UZ) || b == ssl_pkg::CH_US;
    endfunction

    function logic is_digit(logic [7:0] b);
      return b >= ssl_pkg::CH_0 && b <= ssl_pkg::CH_9;
    endfunction

    function void add_tok(logic [4:0] kind, logic [31:0] s, logic [31:0] e);
      ssl_pkg::ssl_tok_t t;
      t.token_kind   = kind;
      t.start_offset = s[ssl_pkg::OUT_W-1:0];
      t.end_offset   = e[ssl_pkg::OUT_W-1:0];
      t.last_of_run  = 1'b0;
      run_tokens.push_back(t);
    endfunction

    // Scans a byte from the idle state.
    function void lex_fresh(logic [7:0] b, logic [31:0] pos);
      logic [31:0] nx;
      nx   = sat_inc(pos);
      mode = ssl_pkg::M_IDLE;
      if (ident_first(b)) begin
        mode      = ssl_pkg::M_IDENT;
        tok_start = pos;
      end else if (is_digit(b)) begin
        mode      = ssl_pkg::M_NUMBER;
        tok_start = pos;
      end else begin
        case (b)
          ssl_pkg::CH_LF: begin
            if (newlines) add_tok(ssl_pkg::K_NEWLINE, pos, nx);
          end
          ssl_pkg::CH_CR, ssl_pkg::CH_TAB, ssl_pkg::CH_SPACE: ;
          ssl_pkg::CH_DQUOTE: begin mode = ssl_pkg::M_STRING; tok_start = pos; end
          ssl_pkg::CH_SLASH:  begin mode = ssl_pkg::M_SLASH;  tok_start = pos; end
          ssl_pkg::CH_EQ:     begin mode = ssl_pkg::M_EQ;     tok_start = pos; end
          ssl_pkg::CH_LT:     begin mode = ssl_pkg::M_LT;     tok_start = pos; end
          ssl_pkg::CH_GT:     begin mode = ssl_pkg::M_GT;     tok_start = pos; end
          ssl_pkg::CH_LBRACE: add_tok(ssl_pkg::K_LBRACE, pos, nx);
          ssl_pkg::CH_RBRACE: add_tok(ssl_pkg::K_RBRACE, pos, nx);
          ssl_pkg::CH_LPAREN: add_tok(ssl_pkg::K_LPAREN, pos, nx);
          ssl_pkg::CH_RPAREN: add_tok(ssl_pkg::K_RPAREN, pos, nx);
          ssl_pkg::CH_SEMI:   add_tok(ssl_pkg::K_SEMI, pos, nx);
          ssl_pkg::CH_COMMA:  add_tok(ssl_pkg::K_COMMA, pos, nx);
          ssl_pkg::CH_PLUS:   add_tok(ssl_pkg::K_PLUS, pos, nx);
          ssl_pkg::CH_MINUS:  add_tok(ssl_pkg::K_MINUS, pos, nx);
          ssl_pkg::CH_STAR:   add_tok(ssl_pkg::K_STAR, pos, nx);
          ssl_pkg::CH_PCT:    add_tok(ssl_pkg::K_PERCENT, pos, nx);
          default:            add_tok(ssl_pkg::K_INVALID, pos, nx);
        endcase
      end
    endfunction

    // A lookahead operator becomes the two-byte form on '=', otherwise it
    // closes as one byte and the current byte is scanned again.
    function void end_op(logic [7:0] b, logic [31:0] pos, logic [4:0] one, logic [4:0] two);
      if (b == ssl_pkg::CH_EQ) begin
        add_tok(two, tok_start, sat_inc(pos));
        mode = ssl_pkg::M_IDLE;
      end else begin
        add_tok(one, tok_start, pos);
        lex_fresh(b, pos);
      end
    endfunction

    function void lex_request(ssl_pkg::ssl_in_t req);
      logic [31:0]       pos;
      ssl_pkg::ssl_tok_t t;
      logic [7:0]        b;
      pos = byte_pos;
      b   = req.source_byte;
      run_tokens.delete();
      if (req.cmd == ssl_pkg::CMD_END) begin
        case (mode)
          ssl_pkg::M_IDENT:  add_tok(ssl_pkg::K_IDENT, tok_start, pos);
          ssl_pkg::M_NUMBER: add_tok(ssl_pkg::K_NUMBER, tok_start, pos);
          ssl_pkg::M_STRING, ssl_pkg::M_STR_ESC: add_tok(ssl_pkg::K_UNTERM, tok_start, pos);
          ssl_pkg::M_SLASH:  add_tok(ssl_pkg::K_SLASH, tok_start, pos);
          ssl_pkg::M_EQ:     add_tok(ssl_pkg::K_ASSIGN, tok_start, pos);
          ssl_pkg::M_LT:     add_tok(ssl_pkg::K_LT, tok_start, pos);
          ssl_pkg::M_GT:     add_tok(ssl_pkg::K_GT, tok_start, pos);
          default: ;
        endcase
        add_tok(ssl_pkg::K_EOF, pos, pos);
        mode      = ssl_pkg::M_IDLE;
        tok_start = '0;
        byte_pos  = '0;
      end else begin
        case (mode)
          ssl_pkg::M_IDENT: begin
            if (!(ident_first(b) || is_digit(b))) begin
              add_tok(ssl_pkg::K_IDENT, tok_start, pos);
              lex_fresh(b, pos);
            end
          end
          ssl_pkg::M_NUMBER: begin
            if (!is_digit(b)) begin
              add_tok(ssl_pkg::K_NUMBER, tok_start, pos);
              lex_fresh(b, pos);
            end
          end
          ssl_pkg::M_STRING: begin
            if (b == ssl_pkg::CH_BSLASH) begin
              mode = ssl_pkg::M_STR_ESC;
            end else if (b == ssl_pkg::CH_DQUOTE) begin
              add_tok(ssl_pkg::K_STRING, tok_start, sat_inc(pos));
              mode = ssl_pkg::M_IDLE;
            end
          end
          ssl_pkg::M_STR_ESC: mode = ssl_pkg::M_STRING;
          ssl_pkg::M_SLASH: begin
            if (b == ssl_pkg::CH_SLASH) mode = ssl_pkg::M_LINE;
            else if (b == ssl_pkg::CH_STAR) mode = ssl_pkg::M_BLOCK;
            else end_op(b, pos, ssl_pkg::K_SLASH, ssl_pkg::K_NE);
          end
          ssl_pkg::M_EQ: end_op(b, pos, ssl_pkg::K_ASSIGN, ssl_pkg::K_EQ);
          ssl_pkg::M_LT: end_op(b, pos, ssl_pkg::K_LT, ssl_pkg::K_LE);
          ssl_pkg::M_GT: end_op(b, pos, ssl_pkg::K_GT, ssl_pkg::K_GE);
          ssl_pkg::M_LINE: begin
            if (b == ssl_pkg::CH_LF) mode = ssl_pkg::M_IDLE;
          end
          ssl_pkg::M_BLOCK: begin
            if (b == ssl_pkg::CH_STAR) mode = ssl_pkg::M_BLOCK_STAR;
          end
          ssl_pkg::M_BLOCK_STAR: begin
            if (b == ssl_pkg::CH_SLASH) mode = ssl_pkg::M_IDLE;
            else if (b != ssl_pkg::CH_STAR) mode = ssl_pkg::M_BLOCK;
          end
          default: lex_fresh(b, pos);
        endcase
        byte_pos = sat_inc(pos);
      end
      if (run_tokens.size() > 0) begin
        t = run_tokens.pop_back();
        t.last_of_run = 1'b1;
        run_tokens.push_back(t);
      end
      foreach (run_tokens[i]) pending_tokens.push_back(run_tokens[i]);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void match_token(ssl_pkg::ssl_tok_t got);
      ssl_pkg::ssl_tok_t want;
      if (pending_tokens.size() == 0) begin
        $error("token with nothing expected: kind %0d, start %0d, end %0d",
               got.token_kind, got.start_offset, got.end_offset);
        errors++;
        return;
      end
      want = pending_tokens.pop_front();
      compare("token_kind", 32'(want.token_kind), 32'(got.token_kind));
      compare("start_offset", 32'(want.start_offset), 32'(got.start_offset));
      compare("end_offset", 32'(want.end_offset), 32'(got.end_offset));
      compare("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  ssl_pkg::ssl_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  ssl_pkg::ssl_tok_t out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_wdata_i = 1'b0;

  lexer_tracker tracker = new();

  // Source text waiting to be streamed, one byte per request.
  logic [7:0] text_q[$];
  int         burst_left = 0;
  int         gap_max    = 0;
  int         items_sent = 0;
  bit         hold_req   = 1'b0;
  int         stuck_cycles = 0;

  script_source_lexer #(
    .OFFSET_WIDTH(POS_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Both handshakes are sampled here, on the values that stood before the edge.
  // The watchdog ends the run once nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) tracker.lex_request(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_token(out_data_o);
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Token receiver. It switches between random stall patterns and, when asked, holds
  // off once so the token queue fills and the input stalls.
  initial begin : token_receiver
    int   pattern;
    int   pattern_left;
    int   hold_left;
    int   tick;
    logic stall;
    bit   hold_done;
    pattern_left = 0;
    hold_left    = 0;
    tick         = 0;
    pattern      = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end
      if (pattern_left == 0) begin
        pattern      = $urandom_range(0, 3);
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        case (pattern)
          0:       stall = 1'b0;
          1:       stall = ($urandom_range(0, 3) == 0);
          2:       stall = ($urandom_range(0, 3) != 0);
          default: stall = ((tick % 4) != 3);
        endcase
      end
      out_stall_i <= stall;
    end
  end

  // Offers one request and returns at the edge that takes it. The sender works in
  // bursts; between bursts valid drops for a random gap unless gaps are switched off.
  task automatic send_request(input logic cmd, input logic [7:0] b);
    ssl_pkg::ssl_in_t req;
    int               gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req.cmd         = cmd;
    req.source_byte = b;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_request(ssl_pkg::CMD_BYTE, text_q[i]);
    text_q.delete();
  endtask

  // Lets every owed token arrive, then lets the block drain, since a byte that yields no
  // token may still be inside the block.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_newlines(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_newlines(v);
  endtask

  function automatic logic [7:0] pick_ident_first();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(ssl_pkg::CH_LA, ssl_pkg::CH_LZ));
      1:       return 8'($urandom_range(ssl_pkg::CH_UA, ssl_pkg::CH_UZ));
      2:       return ssl_pkg::CH_US;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic void add_ident(int len);
    text_q.push_back(pick_ident_first());
    repeat (len) begin
      if ($urandom_range(0, 9) < 3) begin
        text_q.push_back(8'($urandom_range(ssl_pkg::CH_0, ssl_pkg::CH_9)));
      end else begin
        text_q.push_back(pick_ident_first());
      end
    end
  endfunction

  // Appends one lexeme of C-like text. Mostly well-formed, with some noise bytes,
  // unclosed strings and unclosed block comments mixed in.
  function automatic void add_fragment();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      add_ident($urandom_range(0, 6));
    end else if (r < 30) begin
      repeat ($urandom_range(1, 6)) begin
        text_q.push_back(8'($urandom_range(ssl_pkg::CH_0, ssl_pkg::CH_9)));
      end
    end else if (r < 40) begin
      text_q.push_back(ssl_pkg::CH_DQUOTE);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(0, 255));
        if (c == ssl_pkg::CH_DQUOTE) c = "x";
        text_q.push_back(c);
        // An escape may take a quote, a line feed or another backslash.
        if (c == ssl_pkg::CH_BSLASH || $urandom_range(0, 7) == 0) begin
          if (c != ssl_pkg::CH_BSLASH) text_q.push_back(ssl_pkg::CH_BSLASH);
          case ($urandom_range(0, 3))
            0:       text_q.push_back(ssl_pkg::CH_DQUOTE);
            1:       text_q.push_back(ssl_pkg::CH_BSLASH);
            2:       text_q.push_back(ssl_pkg::CH_LF);
            default: text_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      if ($urandom_range(0, 9) != 0) text_q.push_back(ssl_pkg::CH_DQUOTE);
    end else if (r < 50) begin
      text_q.push_back(LOOKAHEAD_CHARS[$urandom_range(0, 3)]);
      text_q.push_back(ssl_pkg::CH_EQ);
    end else if (r < 64) begin
      text_q.push_back(OP_CHARS[$urandom_range(0, 13)]);
    end else if (r < 72) begin
      case ($urandom_range(0, 2))
        0:       text_q.push_back(ssl_pkg::CH_SPACE);
        1:       text_q.push_back(ssl_pkg::CH_TAB);
        default: text_q.push_back(ssl_pkg::CH_CR);
      endcase
    end else if (r < 78) begin
      text_q.push_back(ssl_pkg::CH_LF);
    end else if (r < 83) begin
      text_q.push_back(ssl_pkg::CH_SLASH);
      text_q.push_back(ssl_pkg::CH_SLASH);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(0, 255));
        text_q.push_back((c == ssl_pkg::CH_LF) ? ssl_pkg::CH_SPACE : c);
      end
      text_q.push_back(ssl_pkg::CH_LF);
    end else if (r < 88) begin
      text_q.push_back(ssl_pkg::CH_SLASH);
      text_q.push_back(ssl_pkg::CH_STAR);
      // A slash right after the opener must not close the comment.
      if ($urandom_range(0, 3) == 0) text_q.push_back(ssl_pkg::CH_SLASH);
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 4))
          0:       text_q.push_back(ssl_pkg::CH_STAR);
          1:       text_q.push_back(ssl_pkg::CH_SLASH);
          2:       text_q.push_back(ssl_pkg::CH_LF);
          3:       text_q.push_back(ssl_pkg::CH_SPACE);
          default: text_q.push_back("x");
        endcase
      end
      if ($urandom_range(0, 9) != 0) begin
        text_q.push_back(ssl_pkg::CH_STAR);
        text_q.push_back(ssl_pkg::CH_SLASH);
      end
    end else if (r < 93) begin
      case ($urandom_range(0, 5))
        0:       text_q.push_back(8'($urandom_range(0, 8)));
        1:       text_q.push_back(8'($urandom_range(14, 31)));
        2:       text_q.push_back(8'h7F);
        3:       text_q.push_back("!");
        4:       text_q.push_back("@");
        default: text_q.push_back("~");
      endcase
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 4) text_q.push_back(ssl_pkg::CH_SPACE);
  endfunction

  initial begin : stimulus
    int phase_end;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with newline tokens on: a high byte opening an identifier that a
    // digit continues, a number closed by a string with an escaped quote, all four
    // two-byte operators, a block comment whose opener star does not close it, a line
    // comment that swallows its line feed, a lookahead operator relexing a letter, an
    // identifier closed by a control byte, then end of source on an unclosed string
    // that ends in a backslash.
    write_newlines(1'b1);
    text_q = '{8'hFF, ssl_pkg::CH_9, ssl_pkg::CH_SPACE, ssl_pkg::CH_0,
               ssl_pkg::CH_DQUOTE, ssl_pkg::CH_BSLASH, ssl_pkg::CH_DQUOTE,
               ssl_pkg::CH_DQUOTE, ssl_pkg::CH_LT, ssl_pkg::CH_EQ, ssl_pkg::CH_GT,
               ssl_pkg::CH_EQ, ssl_pkg::CH_SLASH, ssl_pkg::CH_EQ, ssl_pkg::CH_EQ,
               ssl_pkg::CH_EQ, ssl_pkg::CH_SLASH, ssl_pkg::CH_STAR, ssl_pkg::CH_SLASH,
               ssl_pkg::CH_STAR, ssl_pkg::CH_SLASH, ssl_pkg::CH_SLASH, ssl_pkg::CH_SLASH,
               8'h00, ssl_pkg::CH_LF, ssl_pkg::CH_LF, ssl_pkg::CH_LT, ssl_pkg::CH_UA,
               8'h00};
    send_text();
    send_request(ssl_pkg::CMD_END, 8'hFF);
    send_request(ssl_pkg::CMD_BYTE, ssl_pkg::CH_DQUOTE);
    send_request(ssl_pkg::CMD_BYTE, ssl_pkg::CH_BSLASH);
    send_request(ssl_pkg::CMD_END, 8'h00);

    // Random sources, each closed by an end-of-source request. Every phase starts from
    // an idle block with a fresh newline setting; one phase runs with no sender gaps
    // while the receiver holds off, which backs the block up into its input.
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0:       write_newlines(1'b0);
        1:       write_newlines(1'b1);
        default: write_newlines(1'($urandom_range(0, 1)));
      endcase
      gap_max = (ph == 2 || ph == 3) ? 0 : $urandom_range(2, 12);
      if (ph == 3) hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        repeat ($urandom_range(3, 30)) add_fragment();
        send_text();
        send_request(ssl_pkg::CMD_END, 8'($urandom_range(0, 255)));
      end
    end

    wait_idle();
    if (tracker.pending() != 0) $error("%0d tokens never arrived", tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
